[src/tspp_pkg.sv]
`timescale 1ns / 1ps

package tspp_pkg;

  localparam logic [7:0]  PACKET_BYTES  = 8'd188;
  localparam logic [7:0]  SYNC_VALUE    = 8'h47;
  localparam logic [7:0]  PAT_TABLE     = 8'h00;
  localparam logic [7:0]  PMT_TABLE     = 8'h02;
  localparam logic [11:0] OFFSET_MAX    = 12'd4095;
  localparam logic [11:0] PAT_FIRST     = 12'd8;
  localparam logic [11:0] PMT_FIRST     = 12'd12;
  localparam logic [12:0] PMT_PID_RESET = 13'd8191;
  localparam int unsigned TDATA_W       = 56;

  typedef enum logic [1:0] {
    TBL_IDLE = 2'd0,
    TBL_PAT  = 2'd1,
    TBL_PMT  = 2'd2,
    TBL_HDR  = 2'd3
  } tbl_e;

  typedef enum logic [1:0] {
    REC_PAT_ENTRY = 2'd0,
    REC_PMT_ENTRY = 2'd1,
    REC_BAD_SYNC  = 2'd2,
    REC_BAD_TABLE = 2'd3
  } rec_e;

  typedef struct packed {
    logic        valid;
    rec_e        kind;
    logic [15:0] program_number;
    logic [12:0] entry_pid;
    logic [7:0]  stream_kind;
    logic [11:0] descriptor_length;
  } rec_t;

endpackage

[src/tspp_parser.sv]
`timescale 1ns / 1ps

module tspp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_i,
  input  logic             start_i,
  input  logic             cfg_we_i,
  input  logic [12:0]      cfg_data_i,
  output tspp_pkg::rec_t   rec_o
);

  logic [12:0]    pmt_pid_q, pmt_pid_d;
  logic [7:0]     pos_q, pos_d;
  logic [7:0]     hdr_hi_q, hdr_hi_d;
  logic [12:0]    pid_q, pid_d;
  tspp_pkg::tbl_e kind_q, kind_d;
  logic [7:0]     ptr_q, ptr_d;
  logic [11:0]    slh_q, slh_d;
  logic [11:0]    off_q, off_d;
  logic [15:0]    prog_q, prog_d;
  logic [3:0]     pih_q, pih_d;
  logic [39:0]    ea_q, ea_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [11:0]    dskip_q, dskip_d;

  logic           run;
  logic [7:0]     p;
  tspp_pkg::tbl_e kind_cur;
  logic [12:0]    hdr_pid;
  logic [39:0]    ea_n;
  logic [2:0]     cnt_n;
  logic [11:0]    first;
  logic           in_body;

  // next state and record for the input byte; all but pmt_pid_q advance on step_i
  always_comb begin
    pmt_pid_d = cfg_we_i ? cfg_data_i : pmt_pid_q;
    pos_d     = pos_q;
    hdr_hi_d  = hdr_hi_q;
    pid_d     = pid_q;
    kind_d    = kind_q;
    ptr_d     = ptr_q;
    slh_d     = slh_q;
    off_d     = off_q;
    prog_d    = prog_q;
    pih_d     = pih_q;
    ea_d      = ea_q;
    cnt_d     = cnt_q;
    dskip_d   = dskip_q;
    rec_o     = '0;
    run       = 1'b0;
    p         = pos_q;
    kind_cur  = kind_q;
    hdr_pid   = {hdr_hi_q[4:0], data_i};
    ea_n      = {ea_q[31:0], data_i};
    cnt_n     = cnt_q + 3'd1;
    first     = (kind_q == tspp_pkg::TBL_PAT) ? tspp_pkg::PAT_FIRST : tspp_pkg::PMT_FIRST;
    in_body   = ({1'b0, off_q} + 13'd1) < {1'b0, slh_q};

    if (start_i) begin
      run      = 1'b1;
      p        = '0;
      kind_cur = tspp_pkg::TBL_HDR;
      hdr_hi_d = '0;
      pid_d    = '0;
      kind_d   = tspp_pkg::TBL_HDR;
      ptr_d    = '0;
      slh_d    = '0;
      off_d    = '0;
      prog_d   = '0;
      pih_d    = '0;
      ea_d     = '0;
      cnt_d    = '0;
      dskip_d  = '0;
    end else if (pos_q != 8'd0 && pos_q < tspp_pkg::PACKET_BYTES) begin
      run = 1'b1;
    end

    if (run) begin
      pos_d = p + 8'd1;
      if (kind_cur != tspp_pkg::TBL_IDLE) begin
        priority if (p == 8'd0) begin
          if (data_i != tspp_pkg::SYNC_VALUE) begin
            kind_d     = tspp_pkg::TBL_IDLE;
            rec_o.valid = 1'b1;
            rec_o.kind  = tspp_pkg::REC_BAD_SYNC;
          end
        end else if (p == 8'd1) begin
          hdr_hi_d = data_i;
        end else if (p == 8'd2) begin
          pid_d = hdr_pid;
          priority if (!hdr_hi_q[6]) kind_d = tspp_pkg::TBL_IDLE;
          else if (hdr_pid == 13'd0) kind_d = tspp_pkg::TBL_PAT;
          else if (hdr_pid == pmt_pid_q) kind_d = tspp_pkg::TBL_PMT;
          else kind_d = tspp_pkg::TBL_IDLE;
        end else if (p == 8'd3) begin
          ptr_d = ptr_q;
        end else if (p == 8'd4) begin
          ptr_d = data_i;
        end else if (ptr_q != 8'd0) begin
          ptr_d = ptr_q - 8'd1;
        end else begin
          // section byte
          off_d = (off_q == tspp_pkg::OFFSET_MAX) ? off_q : off_q + 12'd1;
          priority if (off_q == 12'd0) begin
            if (data_i != ((kind_q == tspp_pkg::TBL_PAT) ? tspp_pkg::PAT_TABLE
                                                           : tspp_pkg::PMT_TABLE)) begin
              kind_d          = tspp_pkg::TBL_IDLE;
              rec_o.valid     = 1'b1;
              rec_o.kind      = tspp_pkg::REC_BAD_TABLE;
              rec_o.entry_pid = pid_q;
            end
          end else if (off_q == 12'd1) begin
            slh_d = {data_i[3:0], 8'd0};
          end else if (off_q == 12'd2) begin
            slh_d = {slh_q[11:8], data_i};
          end else if (kind_q == tspp_pkg::TBL_PMT && off_q == 12'd3) begin
            prog_d = {data_i, 8'd0};
          end else if (kind_q == tspp_pkg::TBL_PMT && off_q == 12'd4) begin
            prog_d = {prog_q[15:8], data_i};
          end else if (kind_q == tspp_pkg::TBL_PMT && off_q == 12'd10) begin
            pih_d = data_i[3:0];
          end else if (kind_q == tspp_pkg::TBL_PMT && off_q == 12'd11) begin
            dskip_d = {pih_q, data_i};
          end else if (off_q < first || !in_body) begin
            off_d = off_d;
          end else if (dskip_q != 12'd0) begin
            dskip_d = dskip_q - 12'd1;
          end else if (kind_q == tspp_pkg::TBL_PAT) begin
            ea_d = ea_n;
            if (cnt_n >= 3'd4) begin
              cnt_d = '0;
              if (ea_n[31:16] != 16'd0) begin
                rec_o.valid          = 1'b1;
                rec_o.kind           = tspp_pkg::REC_PAT_ENTRY;
                rec_o.program_number = ea_n[31:16];
                rec_o.entry_pid      = ea_n[12:0];
              end
            end else begin
              cnt_d = cnt_n;
            end
          end else begin
            ea_d = ea_n;
            if (cnt_n >= 3'd5) begin
              cnt_d                   = '0;
              dskip_d                 = ea_n[11:0];
              rec_o.valid             = 1'b1;
              rec_o.kind              = tspp_pkg::REC_PMT_ENTRY;
              rec_o.program_number    = prog_q;
              rec_o.entry_pid         = ea_n[28:16];
              rec_o.stream_kind       = ea_n[39:32];
              rec_o.descriptor_length = ea_n[11:0];
            end else begin
              cnt_d = cnt_n;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmt_pid_q <= tspp_pkg::PMT_PID_RESET;
      pos_q     <= '0;
      hdr_hi_q  <= '0;
      pid_q     <= '0;
      kind_q    <= tspp_pkg::TBL_IDLE;
      ptr_q     <= '0;
      slh_q     <= '0;
      off_q     <= '0;
      prog_q    <= '0;
      pih_q     <= '0;
      ea_q      <= '0;
      cnt_q     <= '0;
      dskip_q   <= '0;
    end else begin
      pmt_pid_q <= pmt_pid_d;
      if (step_i) begin
        pos_q     <= pos_d;
        hdr_hi_q  <= hdr_hi_d;
        pid_q     <= pid_d;
        kind_q    <= kind_d;
        ptr_q     <= ptr_d;
        slh_q     <= slh_d;
        off_q     <= off_d;
        prog_q    <= prog_d;
        pih_q     <= pih_d;
        ea_q      <= ea_d;
        cnt_q     <= cnt_d;
        dskip_q   <= dskip_d;
      end
    end
  end

endmodule

[src/ts_pat_pmt_section_parser_unit.sv]
`timescale 1ns / 1ps

// Transport stream PAT / PMT section parser.
// Slave stream: one TS byte per item in s_axis_tdata, s_axis_tuser flags the
// first byte of a 188-byte packet. Master stream: one record per PAT program
// entry, PMT elementary stream, bad sync byte or wrong table id; the record
// kind travels in m_axis_tuser. Most bytes produce no record.
// The PMT PID is written through cfg_we_i / cfg_data_i; the user must do so
// only while the stream is idle, as the block does not enforce it.
// Throughput: one byte per cycle unless a record meets a full stalled output.
// Header, pointer and section parsing is a single pass of counters and field
// captures between the parser state registers and the output register.
// A record appears on the master side the cycle after the byte that completes
// it is accepted. Reset clears all parse state and sets the PMT PID to 8191;
// bytes before the first packet start are dropped.
// When the receiver stalls, the output register holds the record and the
// input keeps accepting bytes as long as they produce no new record; the
// input stalls only when a full output register would be overwritten.
module ts_pat_pmt_section_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // data_byte
  input  logic                          s_axis_tuser,   // packet_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] program_number, [28:16] entry_pid, [36:29] stream_kind,
  // [48:37] descriptor_length, [55:49] zero
  output logic [tspp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // record_kind
  input  logic                          cfg_we_i,
  input  logic [12:0]                   cfg_data_i
);

  tspp_pkg::rec_t rec;
  tspp_pkg::rec_t out_q;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready || !rec.valid;

  tspp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .data_i     (s_axis_tdata),
    .start_i    (s_axis_tuser),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .rec_o      (rec)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (accept && rec.valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && rec.valid) begin
      out_q <= rec;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {7'd0, out_q.descriptor_length, out_q.stream_kind,
                          out_q.entry_pid, out_q.program_number};

endmodule

[src/tspp_checker.sv]
`timescale 1ns / 1ps

module tspp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [tspp_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled record changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_rec_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("record without accepted item");

  a_bad_sync_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tspp_pkg::REC_BAD_SYNC |-> m_axis_tdata == '0)
    else $error("bad sync record carries data");

  a_pat_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tspp_pkg::REC_PAT_ENTRY
      |-> m_axis_tdata[15:0] != 16'd0 && m_axis_tdata[55:29] == '0)
    else $error("malformed PAT entry record");

endmodule

bind ts_pat_pmt_section_parser_unit tspp_checker u_tspp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
